FILE: sv/spr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the script pointer relocator.
// No dependencies.
package spr_pkg;

  localparam int WordWidth    = 32;
  localparam int CountWidth   = 15;
  localparam int QueueDepth   = 2;
  localparam int CfgIdxWidth  = 2;
  localparam int ModNumWidth  = 6;

  localparam logic [7:0]           TagBase    = 8'h40;
  localparam logic [WordWidth-1:0] EndMarker  = 32'h0000_0001;
  localparam int                   CountShift = 16;
  localparam int                   TagShift   = 24;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_DIRECTION     = 2'd0,
    REG_MODULE_NUMBER = 2'd1,
    REG_MODULE_BASE   = 2'd2,
    REG_HELPER_BASE   = 2'd3
  } spr_reg_t;

  typedef enum logic {
    DIR_LINK   = 1'b0,
    DIR_UNLINK = 1'b1
  } spr_dir_t;

  typedef struct packed {
    spr_dir_t                 direction;
    logic [ModNumWidth-1:0]   module_number;
    logic [WordWidth-1:0]     module_base;
    logic [WordWidth-1:0]     helper_base;
  } spr_cfg_t;

  // classified word between front and back
  typedef struct packed {
    logic [WordWidth-1:0] word;
    logic                 hdr;
    logic                 last;
  } spr_item_t;

  typedef struct packed {
    logic [WordWidth-1:0] word;
    logic                 hdr;
    logic                 changed;
    logic                 last;
  } spr_result_t;

endpackage

FILE: sv/spr_fifo.sv
`timescale 1ns / 1ps
// Small register queue with push/full and pop/empty sides.
// Depends on nothing but its parameters.
module spr_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntWidth = $clog2(DEPTH + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] rd_ptr;
  logic [CntWidth-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == FullCnt);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: sv/spr_front.sv
`timescale 1ns / 1ps
// Front end: tracks the argument count and marks each word as header or argument.
// Depends on spr_pkg.
module spr_front import spr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [WordWidth-1:0] word_in,
  output spr_item_t            item
);

  logic [CountWidth-1:0] args_left;
  logic [CountWidth-1:0] args_left_next;
  logic                  at_header;

  assign at_header = (args_left == '0);

  always_comb begin
    item.word = word_in;
    item.hdr  = at_header;
    item.last = at_header && (word_in == EndMarker);
    if (at_header) begin
      // negative count means no arguments
      args_left_next = word_in[WordWidth-1] ? '0
                     : word_in[CountShift +: CountWidth];
    end else begin
      args_left_next = args_left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      args_left <= '0;
    end else if (accept) begin
      args_left <= args_left_next;
    end
  end

endmodule

FILE: sv/spr_back.sv
`timescale 1ns / 1ps
// Back end: relocates argument words and holds results in an output queue.
// Depends on spr_pkg and spr_fifo.
module spr_back import spr_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  spr_cfg_t    cfg,
  input  spr_item_t   item,
  input  logic        item_empty,
  output logic        item_pop,
  input  logic        res_pop,
  output spr_result_t res,
  output logic        res_empty
);

  logic [WordWidth-1:0] tag;
  logic                 in_link;
  logic                 in_unlink;
  logic                 res_full;
  spr_result_t          calc;

  assign tag       = {TagBase + {2'b00, cfg.module_number}, {TagShift{1'b0}}};
  assign in_link   = (item.word[WordWidth-1 -: 2] == 2'b01);
  assign in_unlink = (item.word >= cfg.module_base) && (item.word < cfg.helper_base);
  assign item_pop  = !item_empty && !res_full;

  always_comb begin
    calc.word    = item.word;
    calc.hdr     = item.hdr;
    calc.last    = item.last;
    calc.changed = 1'b0;
    if (!item.hdr) begin
      unique case (cfg.direction)
        DIR_LINK: begin
          if (in_link) begin
            calc.word    = item.word - tag + cfg.module_base;
            calc.changed = 1'b1;
          end
        end
        DIR_UNLINK: begin
          if (in_unlink) begin
            calc.word    = item.word + tag - cfg.module_base;
            calc.changed = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  spr_fifo #(
    .WIDTH($bits(spr_result_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (item_pop),
    .wdata(calc),
    .full (res_full),
    .pop  (res_pop),
    .rdata(res),
    .empty(res_empty)
  );

endmodule

FILE: sv/script_pointer_relocator_core.sv
`timescale 1ns / 1ps
// Script pointer relocator, top level: config registers, front end, queue, back end.
// Depends on spr_pkg, spr_front, spr_fifo, spr_back.
//
// Takes one 32-bit script word per cycle while full is low and returns one
// result beat per word, in order. A pushed word is classified into a two-entry
// queue, is relocated by the back end into a two-entry output queue once that
// queue has room, and is then visible on the result ports. One word per cycle
// is sustained while results are popped, since each queue moves one beat per cycle.
// Each side stalls on its own; full is the first queue's flag, and that queue fills
// only while the output queue is full and holds words back.
// Config writes are always ready; the back end reads the registers as it
// relocates, so write them only while no word is in flight.
module script_pointer_relocator_core import spr_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [WordWidth-1:0]   word_in,
  output logic                   full,
  input  logic                   pop,
  output logic                   empty,
  output logic [WordWidth-1:0]   word_out,
  output logic                   was_header,
  output logic                   was_changed,
  output logic                   last,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [WordWidth-1:0]   cfg_data
);

  spr_cfg_t    cfg;
  spr_item_t   front_item;
  spr_item_t   back_item;
  spr_result_t res;
  logic        accept;
  logic        mid_empty;
  logic        mid_pop;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (spr_reg_t'(cfg_index))
        REG_DIRECTION:     cfg.direction     <= spr_dir_t'(cfg_data[0]);
        REG_MODULE_NUMBER: cfg.module_number <= cfg_data[ModNumWidth-1:0];
        REG_MODULE_BASE:   cfg.module_base   <= cfg_data;
        REG_HELPER_BASE:   cfg.helper_base   <= cfg_data;
        default: ;
      endcase
    end
  end

  spr_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .word_in(word_in),
    .item   (front_item)
  );

  spr_fifo #(
    .WIDTH($bits(spr_item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_mid_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(front_item),
    .full (full),
    .pop  (mid_pop),
    .rdata(back_item),
    .empty(mid_empty)
  );

  spr_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item      (back_item),
    .item_empty(mid_empty),
    .item_pop  (mid_pop),
    .res_pop   (pop),
    .res       (res),
    .res_empty (empty)
  );

  assign word_out    = res.word;
  assign was_header  = res.hdr;
  assign was_changed = res.changed;
  assign last        = res.last;

endmodule

FILE: sv/spr_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the script pointer relocator, bound to the top level.
// Depends on script_pointer_relocator_core.
module spr_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] word_out,
  input logic        was_header,
  input logic        was_changed,
  input logic        last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  a_last_is_header: assert property (@(posedge clk) disable iff (rst)
    (!empty && last) |-> was_header)
    else $error("last beat not marked as header");

  a_header_unchanged: assert property (@(posedge clk) disable iff (rst)
    (!empty && was_header) |-> !was_changed)
    else $error("header beat marked as relocated");

  a_last_word: assert property (@(posedge clk) disable iff (rst)
    (!empty && last) |-> (word_out == 32'h0000_0001))
    else $error("last beat carries wrong word");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(word_out)))
    else $error("waiting result beat changed");

endmodule

bind script_pointer_relocator_core spr_checker u_spr_checker (.*);

FILE: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for script_pointer_relocator_core: scripted and random
// word streams, compared beat by beat against an in-bench relocation predictor.
// Depends on spr_pkg and the core RTL.
module tb;
  import spr_pkg::*;

  localparam logic [31:0] LinkLo    = 32'h4000_0000;
  localparam logic [31:0] LinkHi    = 32'h8000_0000;
  localparam int          StallLimit = 5000;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic [WordWidth-1:0] word_in = '0;
  logic                 full;
  logic                 pop = 1'b0;
  logic                 empty;
  logic [WordWidth-1:0] word_out;
  logic                 was_header;
  logic                 was_changed;
  logic                 last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  spr_reg_t             cfg_index = REG_DIRECTION;
  logic [WordWidth-1:0] cfg_data = '0;

  logic [WordWidth-1:0]  script_q[$];
  spr_result_t           relocated_q[$];
  spr_cfg_t              cfg_shadow = '0;
  logic [CountWidth-1:0] args_pending = '0;
  int                    gen_left = 0;
  int                    gap_pct = 0;
  int                    stall_pct = 0;
  int                    bad_beats = 0;
  int                    idle_cycles = 0;

  script_pointer_relocator_core u_top (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .word_in     (word_in),
    .full        (full),
    .pop         (pop),
    .empty       (empty),
    .word_out    (word_out),
    .was_header  (was_header),
    .was_changed (was_changed),
    .last        (last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic spr_result_t relocate_word(logic [WordWidth-1:0] w);
    spr_result_t          r;
    logic [WordWidth-1:0] tag;
    tag = {TagBase + {2'b00, cfg_shadow.module_number}, 24'h0};
    r.word = w;
    r.hdr = 1'b0;
    r.changed = 1'b0;
    r.last = 1'b0;
    if (args_pending == '0) begin
      r.hdr = 1'b1;
      args_pending = w[31] ? '0 : w[30:16];
      r.last = (w == EndMarker);
    end else begin
      args_pending = args_pending - 1'b1;
      if (cfg_shadow.direction == DIR_LINK) begin
        if (w >= LinkLo && w < LinkHi) begin
          r.word = w - tag + cfg_shadow.module_base;
          r.changed = 1'b1;
        end
      end else if (w >= cfg_shadow.module_base && w < cfg_shadow.helper_base) begin
        r.word = w + tag - cfg_shadow.module_base;
        r.changed = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [WordWidth-1:0] arg_word();
    logic [WordWidth-1:0] corner[10];
    logic [WordWidth-1:0] span;
    logic [WordWidth-1:0] rnd;
    int                   pick;
    rnd = $urandom;
    pick = $urandom_range(19);
    span = cfg_shadow.helper_base - cfg_shadow.module_base;
    corner = '{LinkLo, LinkLo - 1, LinkHi, LinkHi - 1, cfg_shadow.module_base,
               cfg_shadow.module_base - 1, cfg_shadow.helper_base,
               cfg_shadow.helper_base - 1, 32'h0, 32'hFFFF_FFFF};
    if (pick < 4)
      return {TagBase + {2'b00, cfg_shadow.module_number}, rnd[23:0]};
    else if (pick < 7)
      return {2'b01, rnd[29:0]};
    else if (pick < 11)
      return (cfg_shadow.helper_base > cfg_shadow.module_base) ?
             cfg_shadow.module_base + (rnd % span) : rnd;
    else if (pick < 14)
      return corner[$urandom_range(9)];
    else if (pick == 14)
      return EndMarker;
    else if (pick == 15)
      return {1'b0, 12'h0, rnd[18:0]};
    return rnd;
  endfunction

  // headers only where the block will read one, so scripts stay in step
  task automatic next_word();
    logic [WordWidth-1:0] w;
    int                   pick;
    w = $urandom;
    if (gen_left == 0) begin
      pick = $urandom_range(19);
      if (pick < 2)
        w[31] = 1'b1;
      else if (pick < 4)
        w = EndMarker;
      else if (pick < 6)
        w[31:16] = 16'h0;
      else if (pick == 6)
        w[31:16] = 16'($urandom_range(40, 8));
      else
        w[31:16] = 16'($urandom_range(6, 1));
      gen_left = w[31] ? 0 : int'(w[30:16]);
    end else begin
      gen_left--;
      w = arg_word();
    end
    script_q.push_back(w);
  endtask

  task automatic set_reg(spr_reg_t idx, logic [WordWidth-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DIRECTION:     cfg_shadow.direction = spr_dir_t'(data[0]);
      REG_MODULE_NUMBER: cfg_shadow.module_number = data[ModNumWidth-1:0];
      REG_MODULE_BASE:   cfg_shadow.module_base = data;
      REG_HELPER_BASE:   cfg_shadow.helper_base = data;
      default: ;
    endcase
  endtask

  task automatic configure(spr_dir_t dir, logic [ModNumWidth-1:0] num,
                           logic [WordWidth-1:0] base, logic [WordWidth-1:0] helper);
    logic [WordWidth-1:0] junk;
    junk = $urandom_range(1) ? $urandom : '0;
    @(posedge clk);
    set_reg(REG_MODULE_BASE, base);
    set_reg(REG_DIRECTION, {junk[31:1], dir});
    set_reg(REG_HELPER_BASE, helper);
    set_reg(REG_MODULE_NUMBER, {junk[31:6], num});
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (script_q.size() != 0 || push || relocated_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic flag_beat(string why, spr_result_t exp);
    bad_beats++;
    if (bad_beats <= 10)
      $display("%0t %s: exp %h h%b c%b l%b / got %h h%b c%b l%b", $time, why,
               exp.word, exp.hdr, exp.changed, exp.last,
               word_out, was_header, was_changed, last);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full)
        relocated_q.push_back(relocate_word(word_in));
      if (!push || !full) begin
        if (script_q.size() > 0 && $urandom_range(99) >= gap_pct) begin
          push <= 1'b1;
          word_in <= script_q.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (relocated_q.size() == 0) begin
          flag_beat("unexpected beat", '0);
        end else if (word_out !== relocated_q[0].word || was_header !== relocated_q[0].hdr ||
                     was_changed !== relocated_q[0].changed ||
                     last !== relocated_q[0].last) begin
          flag_beat("mismatch", relocated_q.pop_front());
        end else begin
          void'(relocated_q.pop_front());
        end
      end
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [WordWidth-1:0] link_seq[13];
    logic [WordWidth-1:0] unlink_seq[7];
    logic [WordWidth-1:0] lo;
    logic [WordWidth-1:0] hi;
    link_seq = '{32'h0004_ABCD, 32'h4000_0000, 32'h7FFF_FFFF, 32'h3FFF_FFFF,
                 32'h8000_0000, 32'hFFFF_FFFF, 32'h8003_0000, 32'h0000_0001,
                 32'h0000_0000, 32'h0001_0001, 32'h0000_0001, 32'h0000_0001,
                 32'h0003_0000};
    unlink_seq = '{32'h0005_0000, 32'h8000_1000, 32'h800F_FFFF, 32'h8010_0000,
                   32'h8000_0FFF, 32'h0000_0001, 32'h0000_0001};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 9; p++) begin
      lo = $urandom;
      hi = $urandom;
      case (p)
        1: configure(DIR_UNLINK, 6'd63, 32'h8000_1000, 32'h8010_0000);
        2: configure(DIR_LINK, 6'd63, 32'hFFFF_FFFF, 32'h0);
        3: configure(DIR_UNLINK, 6'd0, 32'h0, 32'hFFFF_FFFF);
        4: configure(DIR_UNLINK, 6'($urandom_range(63)), 32'h9000_0000, 32'h9000_0000);
        5: configure(DIR_UNLINK, 6'($urandom_range(63)), 32'hC000_0000, 32'h2000_0000);
        6: configure(DIR_LINK, 6'($urandom_range(63)), lo, hi);
        7: configure(DIR_UNLINK, 6'($urandom_range(63)), (lo < hi) ? lo : hi,
                     (lo < hi) ? hi : lo);
        8: configure(DIR_LINK, 6'($urandom_range(63)), lo, hi);
        default: ;
      endcase
      case (p % 4)
        1: begin gap_pct = 60; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 60; end
        3: begin gap_pct = 19; stall_pct = 19; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      if (p == 0) begin
        foreach (link_seq[i]) script_q.push_back(link_seq[i]);
        gen_left = 3;
      end
      if (p == 1) begin
        while (gen_left > 0) next_word();
        foreach (unlink_seq[i]) script_q.push_back(unlink_seq[i]);
      end
      if (p == 8) begin
        // header with the largest count
        while (gen_left > 0) next_word();
        script_q.push_back(32'h7FFF_5A5A);
        gen_left = 32'h7FFF;
      end
      repeat (130) next_word();
      drain();
    end
    if (bad_beats == 0 && relocated_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
